@@ hw/rtl/prfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfe_pkg
// Shared constants, types and helpers of the pulse record feature extractor.
// ----------------------------------------------------------------------------
package prfe_pkg;

	// Record geometry
	localparam int RECORD_LENGTH    = 1024;
	localparam int STATS_WINDOW     = 1000;
	localparam int BASELINE_SAMPLES = 20;
	localparam int SAMPLE_BITS      = 14;

	// Field widths
	localparam int SMP_W   = 14;
	localparam int IDX_W   = 10;
	localparam int SUM_W   = 19;
	localparam int CNT_W   = 11;
	localparam int OFF_W   = 14;
	localparam int REG_W   = 3;
	localparam int SC_W    = 21;
	localparam int POS_W   = $clog2(RECORD_LENGTH);
	localparam int BUF_W   = $clog2(BASELINE_SAMPLES);
	localparam int DRN_W   = $clog2(BASELINE_SAMPLES + 1);
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
	localparam int NUM_CNT = 6;

	localparam logic [SMP_W-1:0] SAMPLE_MASK = SMP_W'((32'd1 << SAMPLE_BITS) - 32'd1);
	localparam logic [CNT_W-1:0] CNT_MAX     = '1;

	// Configuration register indexes
	typedef enum logic [REG_W-1:0] {
		REG_BELOW_HIGH = 3'd0,
		REG_BELOW_MID  = 3'd1,
		REG_BELOW_LOW  = 3'd2,
		REG_ABOVE_HIGH = 3'd3,
		REG_ABOVE_MID  = 3'd4,
		REG_ABOVE_LOW  = 3'd5
	} prfe_reg_t;

	// One classified sample as passed from the front to the back
	typedef struct packed {
		logic [SMP_W-1:0] smp;    // sample, masked to the converter width
		logic [POS_W-1:0] pos;    // position in the record
		logic             first;  // position one, also stands for position zero
		logic             base;   // part of the baseline sum
		logic             trk;    // inside the statistics window
		logic             cls;    // classified on arrival
		logic             bfull;  // completes the baseline sum
		logic             fin;    // closes the record
	} prfe_item_t;

	typedef logic [NUM_CNT-1:0][CNT_W-1:0] prfe_cnt_t;
	typedef logic [NUM_CNT-1:0][OFF_W-1:0] prfe_off_t;

	// Constant scaling by the baseline length
	function automatic logic [SC_W-1:0] scale(input logic [OFF_W-1:0] x);
		scale = SC_W'(x) * SC_W'(BASELINE_SAMPLES);
	endfunction

	// Excursion hits of one sample: below counters 0..2, above counters 3..5
	function automatic logic [NUM_CNT-1:0] hits(input logic [SMP_W-1:0] v,
			input logic [SUM_W-1:0] sum, input prfe_off_t off);
		logic [SC_W-1:0] vs;
		logic [SC_W-1:0] ss;
		vs = scale(v);
		ss = SC_W'(sum);
		for (int k = 0; k < 3; k++) begin
			hits[k] = (vs + scale(off[k])) < ss;
		end
		for (int k = 3; k < NUM_CNT; k++) begin
			hits[k] = vs > (ss + scale(off[k]));
		end
	endfunction

endpackage

@@ hw/rtl/pulse_record_feature_extractor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_record_feature_extractor
// Per-record minimum, maximum, baseline sum and excursion counts of a
// digitizer waveform.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  input    | in_valid / in_ready   | sample, last
//  result   | out_valid / out_ready | min/max value and index, baseline_sum,
//           |                       | six excursion counts
//  config   | cfg_we                | cfg_index, cfg_data
//
// One sample is accepted per cycle while the queue has room. A result is taken
// into the output register after its closing sample leaves the queue. Once the
// baseline sum is complete, 21 buffered samples are classified one per cycle
// next to the live stream; a record closing before that drain is done stops
// queue reads until the drain ends. A four-entry queue separates the front
// from the back, so a stalled result side holds input only after it fills.
// Reset clears all record state; the offset registers return to defaults.
// ----------------------------------------------------------------------------
module pulse_record_feature_extractor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [prfe_pkg::REG_W-1:0] cfg_index,
	input  logic [prfe_pkg::OFF_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [prfe_pkg::SMP_W-1:0] sample,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [prfe_pkg::SMP_W-1:0] min_value,
	output logic [prfe_pkg::IDX_W-1:0] min_index,
	output logic [prfe_pkg::SMP_W-1:0] max_value,
	output logic [prfe_pkg::IDX_W-1:0] max_index,
	output logic [prfe_pkg::SUM_W-1:0] baseline_sum,
	output logic [prfe_pkg::CNT_W-1:0] count_below_high,
	output logic [prfe_pkg::CNT_W-1:0] count_below_mid,
	output logic [prfe_pkg::CNT_W-1:0] count_below_low,
	output logic [prfe_pkg::CNT_W-1:0] count_above_high,
	output logic [prfe_pkg::CNT_W-1:0] count_above_mid,
	output logic [prfe_pkg::CNT_W-1:0] count_above_low
);
	import prfe_pkg::*;

	logic       push, q_ready, q_valid, pop;
	prfe_item_t item, head;
	prfe_cnt_t  counts;

	prfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.last     (last),
		.push     (push),
		.item     (item),
		.q_ready  (q_ready)
	);

	prfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (item),
		.ready     (q_ready),
		.pop       (pop),
		.head      (head),
		.valid     (q_valid)
	);

	prfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_valid      (q_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.min_value    (min_value),
		.min_index    (min_index),
		.max_value    (max_value),
		.max_index    (max_index),
		.baseline_sum (baseline_sum),
		.counts       (counts)
	);

	// Counter order: below high, mid, low, then above high, mid, low.
	assign count_below_high = counts[REG_BELOW_HIGH];
	assign count_below_mid  = counts[REG_BELOW_MID];
	assign count_below_low  = counts[REG_BELOW_LOW];
	assign count_above_high = counts[REG_ABOVE_HIGH];
	assign count_above_mid  = counts[REG_ABOVE_MID];
	assign count_above_low  = counts[REG_ABOVE_LOW];

endmodule

@@ hw/rtl/prfe_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfe_front
// Accepts samples, tracks the record position and tags each request with
// the work that the back end has to do on it.
// ----------------------------------------------------------------------------
module prfe_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [prfe_pkg::SMP_W-1:0] sample,
	input  logic                       last,
	output logic                       push,
	output prfe_pkg::prfe_item_t       item,
	input  logic                       q_ready
);
	import prfe_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [31:0]      p;

	assign in_ready = q_ready;
	assign push     = in_valid & q_ready;
	assign p        = 32'(pos_q);

	// Classify the sample by its position in the record.
	always_comb begin
		item.smp   = sample & SAMPLE_MASK;
		item.pos   = pos_q;
		item.first = (p == 32'd1);
		item.base  = (p >= 32'd1) && (p <= BASELINE_SAMPLES);
		item.trk   = (p >= 32'd1) && (p < STATS_WINDOW);
		item.cls   = (p > BASELINE_SAMPLES) && (p < STATS_WINDOW);
		item.bfull = (p == BASELINE_SAMPLES);
		item.fin   = last || ((p + 32'd1) >= RECORD_LENGTH);
	end

	// Position counter; a closing sample restarts the record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= item.fin ? '0 : pos_q + POS_W'(1);
		end
	end

endmodule

@@ hw/rtl/prfe_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfe_queue
// Short first-in first-out queue of classified samples between the front
// and the back end.
// ----------------------------------------------------------------------------
module prfe_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  prfe_pkg::prfe_item_t push_item,
	output logic                 ready,
	input  logic                 pop,
	output prfe_pkg::prfe_item_t head,
	output logic                 valid
);
	import prfe_pkg::*;

	prfe_item_t           mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q;
	logic [Q_PTR_W-1:0]   rd_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	assign valid = (cnt_q != '0);
	assign ready = (cnt_q != Q_CNT_W'(Q_DEPTH));
	assign head  = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

endmodule

@@ hw/rtl/prfe_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfe_back
// Extremes, baseline sum, early sample buffer, excursion counters and the
// result register. Buffered early samples are classified one per cycle
// alongside the live stream once the baseline sum is complete.
// ----------------------------------------------------------------------------
module prfe_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [prfe_pkg::REG_W-1:0]  cfg_index,
	input  logic [prfe_pkg::OFF_W-1:0]  cfg_data,
	input  logic                        q_valid,
	input  prfe_pkg::prfe_item_t        head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [prfe_pkg::SMP_W-1:0]  min_value,
	output logic [prfe_pkg::IDX_W-1:0]  min_index,
	output logic [prfe_pkg::SMP_W-1:0]  max_value,
	output logic [prfe_pkg::IDX_W-1:0]  max_index,
	output logic [prfe_pkg::SUM_W-1:0]  baseline_sum,
	output prfe_pkg::prfe_cnt_t         counts
);
	import prfe_pkg::*;

	prfe_off_t          off_q;
	logic [SMP_W-1:0]   min_q, max_q, min_n, max_n;
	logic [IDX_W-1:0]   minpos_q, maxpos_q, minpos_n, maxpos_n;
	logic [SUM_W-1:0]   sum_q, sum_n;
	prfe_cnt_t          cnt_q, cnt_n;
	logic [SMP_W-1:0]   buf_q [BASELINE_SAMPLES];
	logic               dact_q, dact_n;
	logic [DRN_W-1:0]   drn_q, drn_n;
	logic               flush_q, flush_n;
	logic [BUF_W-1:0]   dix;
	logic [SMP_W-1:0]   dv;
	logic [NUM_CNT-1:0] hh, dh;
	logic [IDX_W-1:0]   idx;
	logic [CNT_W:0]     csum;
	logic               endreq, out_free, emit;

	logic               ov_q;
	logic [SMP_W-1:0]   omin_q, omax_q;
	logic [IDX_W-1:0]   ominpos_q, omaxpos_q;
	logic [SUM_W-1:0]   osum_q;
	prfe_cnt_t          ocnt_q;

	// Record update for the request at the head of the queue and the drain
	always_comb begin
		pop = q_valid & ~flush_q;

		// Drain entry zero stands for position zero, a copy of position one.
		dix = (drn_q == '0) ? '0 : BUF_W'(drn_q - DRN_W'(1));
		dv  = buf_q[dix];
		hh  = hits(head.smp, sum_q, off_q) & {NUM_CNT{pop & head.cls}};
		dh  = hits(dv, sum_q, off_q) & {NUM_CNT{dact_q}};

		for (int k = 0; k < NUM_CNT; k++) begin
			csum = {1'b0, cnt_q[k]} + (CNT_W + 1)'(hh[k]) + (CNT_W + 1)'(dh[k]);
			cnt_n[k] = (csum > {1'b0, CNT_MAX}) ? CNT_MAX : csum[CNT_W-1:0];
		end

		idx      = head.first ? '0 : IDX_W'(head.pos);
		min_n    = min_q;
		minpos_n = minpos_q;
		max_n    = max_q;
		maxpos_n = maxpos_q;
		if (pop && head.trk) begin
			if (head.smp < min_q) begin
				min_n    = head.smp;
				minpos_n = idx;
			end
			if (head.smp > max_q) begin
				max_n    = head.smp;
				maxpos_n = idx;
			end
		end

		sum_n = sum_q + ((pop && head.base) ? SUM_W'(head.smp) : '0);

		dact_n = dact_q;
		drn_n  = drn_q;
		if (dact_q) begin
			if (drn_q == DRN_W'(BASELINE_SAMPLES)) begin
				dact_n = 1'b0;
			end else begin
				drn_n = drn_q + DRN_W'(1);
			end
		end else if (pop && head.bfull) begin
			dact_n = 1'b1;
			drn_n  = '0;
		end

		endreq   = flush_q | (pop & head.fin);
		out_free = ~ov_q | out_ready;
		emit     = endreq & ~dact_n & out_free;
		flush_n  = endreq & ~emit;
	end

	// Offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q[REG_BELOW_HIGH] <= OFF_W'(2500);
			off_q[REG_BELOW_MID]  <= OFF_W'(1250);
			off_q[REG_BELOW_LOW]  <= OFF_W'(500);
			off_q[REG_ABOVE_HIGH] <= OFF_W'(600);
			off_q[REG_ABOVE_MID]  <= OFF_W'(300);
			off_q[REG_ABOVE_LOW]  <= OFF_W'(120);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BELOW_HIGH: off_q[REG_BELOW_HIGH] <= cfg_data;
				REG_BELOW_MID:  off_q[REG_BELOW_MID]  <= cfg_data;
				REG_BELOW_LOW:  off_q[REG_BELOW_LOW]  <= cfg_data;
				REG_ABOVE_HIGH: off_q[REG_ABOVE_HIGH] <= cfg_data;
				REG_ABOVE_MID:  off_q[REG_ABOVE_MID]  <= cfg_data;
				REG_ABOVE_LOW:  off_q[REG_ABOVE_LOW]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Early sample buffer
	always_ff @(posedge clk) begin
		if (pop && head.base) begin
			buf_q[BUF_W'(head.pos - POS_W'(1))] <= head.smp;
		end
	end

	// Record state; cleared when the result is taken into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= SAMPLE_MASK;
			minpos_q <= '0;
			max_q    <= '0;
			maxpos_q <= '0;
			sum_q    <= '0;
			cnt_q    <= '0;
			dact_q   <= 1'b0;
			drn_q    <= '0;
			flush_q  <= 1'b0;
		end else begin
			dact_q  <= dact_n;
			drn_q   <= drn_n;
			flush_q <= flush_n;
			if (emit) begin
				min_q    <= SAMPLE_MASK;
				minpos_q <= '0;
				max_q    <= '0;
				maxpos_q <= '0;
				sum_q    <= '0;
				cnt_q    <= '0;
			end else begin
				min_q    <= min_n;
				minpos_q <= minpos_n;
				max_q    <= max_n;
				maxpos_q <= maxpos_n;
				sum_q    <= sum_n;
				cnt_q    <= cnt_n;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			omin_q    <= min_n;
			ominpos_q <= minpos_n;
			omax_q    <= max_n;
			omaxpos_q <= maxpos_n;
			osum_q    <= sum_n;
			ocnt_q    <= cnt_n;
		end
	end

	assign out_valid    = ov_q;
	assign min_value    = omin_q;
	assign min_index    = ominpos_q;
	assign max_value    = omax_q;
	assign max_index    = omaxpos_q;
	assign baseline_sum = osum_q;
	assign counts       = ocnt_q;

endmodule

@@ hw/rtl/prfe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfe_checker
// Port-level checks of the feature extractor, bound to its top level.
// ----------------------------------------------------------------------------
module prfe_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [prfe_pkg::SMP_W-1:0] min_value,
	input logic [prfe_pkg::SMP_W-1:0] max_value,
	input logic [prfe_pkg::SUM_W-1:0] baseline_sum,
	input logic [prfe_pkg::CNT_W-1:0] count_above_low,
	input logic [prfe_pkg::CNT_W-1:0] count_below_low
);
	import prfe_pkg::*;

	// A stalled result keeps its valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its baseline sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(baseline_sum))
		else $error("result changed while stalled");

	// The minimum never exceeds the maximum unless no sample was tracked.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (min_value <= max_value) ||
			(min_value == SAMPLE_MASK && max_value == '0))
		else $error("minimum above maximum");

	// Neither the above-low nor the below-low count exceeds the record length.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count_above_low <= CNT_W'(1024)) &&
			(count_below_low <= CNT_W'(1024)))
		else $error("excursion count out of range");

endmodule

bind pulse_record_feature_extractor prfe_checker u_prfe_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.min_value       (min_value),
	.max_value       (max_value),
	.baseline_sum    (baseline_sum),
	.count_above_low (count_above_low),
	.count_below_low (count_below_low)
);

@@ tb/tb_pulse_record_feature_extractor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_record_feature_extractor
// Self-checking bench of the pulse record feature extractor. Records of
// samples are sent through the request handshake under random idling on
// both sides. Each result is compared with a behavioural predictor of the
// record statistics, over several settings of the offset registers.
// ----------------------------------------------------------------------------
module tb_pulse_record_feature_extractor;
	import prfe_pkg::*;

	localparam logic [REG_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_W-1:0] REG_SPARE_B = 3'd7;
	localparam int SMP_MAX = (1 << SMP_W) - 1;

	typedef struct packed {
		logic [SMP_W-1:0] min_v;
		logic [IDX_W-1:0] min_i;
		logic [SMP_W-1:0] max_v;
		logic [IDX_W-1:0] max_i;
		logic [SUM_W-1:0] bsum;
		logic [CNT_W-1:0] c_bh;
		logic [CNT_W-1:0] c_bm;
		logic [CNT_W-1:0] c_bl;
		logic [CNT_W-1:0] c_ah;
		logic [CNT_W-1:0] c_am;
		logic [CNT_W-1:0] c_al;
	} feat_t;

	typedef struct {
		logic [SMP_W-1:0] smp;
		bit               lst;
		bit               typed;
		feat_t            want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_W-1:0]     cfg_index;
	logic [OFF_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [SMP_W-1:0]     sample;
	logic                 last;
	logic                 out_valid;
	logic                 out_ready;
	feat_t                got;

	// Predictor state
	int unsigned offsets [NUM_CNT];
	int unsigned rec_pos;
	int unsigned run_min, run_min_pos, run_max, run_max_pos;
	int unsigned base_acc;
	int unsigned early [BASELINE_SAMPLES];
	int unsigned exc_cnt [NUM_CNT];

	feat_t    expected_feats [$];
	dir_row_t dir_rows [$];
	bit       failed;
	bit       idle_in;
	bit       idle_out;
	bit       hold_req;
	int       phase_items;

	pulse_record_feature_extractor uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.min_value(got.min_v), .min_index(got.min_i),
		.max_value(got.max_v), .max_index(got.max_i),
		.baseline_sum(got.bsum),
		.count_below_high(got.c_bh), .count_below_mid(got.c_bm),
		.count_below_low(got.c_bl), .count_above_high(got.c_ah),
		.count_above_mid(got.c_am), .count_above_low(got.c_al)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb_pulse_record_feature_extractor NOT OK");
		$finish;
	end

	// Record state returns to its idle values after every result.
	function automatic void clear_record();
		rec_pos = 0;
		run_min = SMP_MAX;
		run_min_pos = 0;
		run_max = 0;
		run_max_pos = 0;
		base_acc = 0;
		for (int k = 0; k < NUM_CNT; k++) exc_cnt[k] = 0;
	endfunction

	function automatic void track(int unsigned v, int unsigned idx);
		if (v < run_min) begin
			run_min = v;
			run_min_pos = idx;
		end
		if (v > run_max) begin
			run_max = v;
			run_max_pos = idx;
		end
	endfunction

	// Exact comparison of twenty times the sample against the scaled bounds.
	function automatic void classify(int unsigned v);
		longint scaled;
		longint bsum;
		scaled = longint'(v) * BASELINE_SAMPLES;
		bsum = longint'(base_acc);
		for (int k = 0; k < 3; k++)
			if (scaled < bsum - longint'(offsets[k]) * BASELINE_SAMPLES && exc_cnt[k] < 2047)
				exc_cnt[k]++;
		for (int k = 3; k < NUM_CNT; k++)
			if (scaled > bsum + longint'(offsets[k]) * BASELINE_SAMPLES && exc_cnt[k] < 2047)
				exc_cnt[k]++;
	endfunction

	// Advances the record by one sample; returns 1 when the record closes.
	function automatic bit feature_step(logic [SMP_W-1:0] smp, bit lst, output feat_t r);
		int unsigned v;
		int unsigned p;
		v = smp;
		p = rec_pos;
		r = '0;
		if (p >= 1 && p <= BASELINE_SAMPLES) begin
			early[p-1] = v;
			base_acc += v;
		end
		if (p >= 1 && p < STATS_WINDOW) begin
			if (p == 1) track(v, 0);
			track(v, p);
		end
		// The sample at index one also stands for index zero.
		if (p == BASELINE_SAMPLES) begin
			classify(early[0]);
			for (int i = 0; i < BASELINE_SAMPLES; i++) classify(early[i]);
		end else if (p > BASELINE_SAMPLES && p < STATS_WINDOW) begin
			classify(v);
		end
		if (lst || p + 1 >= RECORD_LENGTH) begin
			r.min_v = SMP_W'(run_min);
			r.min_i = IDX_W'(run_min_pos);
			r.max_v = SMP_W'(run_max);
			r.max_i = IDX_W'(run_max_pos);
			r.bsum  = SUM_W'(base_acc);
			r.c_bh  = CNT_W'(exc_cnt[0]);
			r.c_bm  = CNT_W'(exc_cnt[1]);
			r.c_bl  = CNT_W'(exc_cnt[2]);
			r.c_ah  = CNT_W'(exc_cnt[3]);
			r.c_am  = CNT_W'(exc_cnt[4]);
			r.c_al  = CNT_W'(exc_cnt[5]);
			clear_record();
			return 1'b1;
		end
		rec_pos = p + 1;
		return 1'b0;
	endfunction

	task automatic write_reg(logic [REG_W-1:0] idx, logic [OFF_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx < NUM_CNT) offsets[idx] = val;
		@(negedge clk);
	endtask

	task automatic write_all(logic [OFF_W-1:0] v0, logic [OFF_W-1:0] v1,
			logic [OFF_W-1:0] v2, logic [OFF_W-1:0] v3,
			logic [OFF_W-1:0] v4, logic [OFF_W-1:0] v5);
		write_reg(REG_BELOW_HIGH, v0);
		write_reg(REG_BELOW_MID, v1);
		write_reg(REG_BELOW_LOW, v2);
		write_reg(REG_ABOVE_HIGH, v3);
		write_reg(REG_ABOVE_MID, v4);
		write_reg(REG_ABOVE_LOW, v5);
		// Indexes past the last register must leave every offset alone.
		write_reg(REG_SPARE_A, 14'h3FFF);
		write_reg(REG_SPARE_B, 14'h0000);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Sends one sample request; a typed row replaces the predicted result.
	task automatic send(logic [SMP_W-1:0] smp, bit lst, bit typed, feat_t want);
		int gap;
		feat_t r;
		gap = idle_in ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= smp;
		last <= lst;
		do @(posedge clk); while (!in_ready);
		if (feature_step(smp, lst, r)) expected_feats.push_back(typed ? want : r);
		phase_items++;
		@(negedge clk);
	endtask

	// Waits until every result has arrived and the drain has finished.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_feats.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// A record with a level, a noise amplitude and occasional spikes.
	task automatic send_record(int len);
		int lvl, amp, v;
		bit wide;
		lvl = $urandom_range(0, SMP_MAX);
		case ($urandom_range(0, 3))
			0: amp = 0;
			1: amp = 60;
			2: amp = 600;
			default: amp = 3000;
		endcase
		wide = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < len; i++) begin
			if (wide || $urandom_range(0, 30) == 0) v = $urandom_range(0, SMP_MAX);
			else v = lvl + $urandom_range(0, 2 * amp) - amp;
			if (v < 0) v = 0;
			if (v > SMP_MAX) v = SMP_MAX;
			send(SMP_W'(v), i == len - 1, 1'b0, '0);
		end
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned have);
		if (want != have) begin
			$error("%s: expected %0d, got %0d", name, want, have);
			failed = 1'b1;
		end
	endtask

	// Result side: random stalls, one long hold-off on request.
	initial begin
		feat_t w;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end else if (idle_out) begin
				int stall;
				stall = $urandom_range(0, 15);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (expected_feats.size() == 0) begin
				$error("result with no record pending");
				failed = 1'b1;
			end else begin
				w = expected_feats.pop_front();
				check_field("min_value", w.min_v, got.min_v);
				check_field("min_index", w.min_i, got.min_i);
				check_field("max_value", w.max_v, got.max_v);
				check_field("max_index", w.max_i, got.max_i);
				check_field("baseline_sum", w.bsum, got.bsum);
				check_field("count_below_high", w.c_bh, got.c_bh);
				check_field("count_below_mid", w.c_bm, got.c_bm);
				check_field("count_below_low", w.c_bl, got.c_bl);
				check_field("count_above_high", w.c_ah, got.c_ah);
				check_field("count_above_mid", w.c_am, got.c_am);
				check_field("count_above_low", w.c_al, got.c_al);
			end
			@(negedge clk);
		end
	end

	task automatic add_row(logic [SMP_W-1:0] smp, bit lst, bit typed, feat_t want);
		dir_row_t row;
		row.smp = smp;
		row.lst = lst;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	// Stimulus
	initial begin
		feat_t f;
		failed = 1'b0;
		hold_req = 1'b0;
		idle_in = 1'b1;
		idle_out = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = '0;
		last = 1'b0;
		offsets = '{2500, 1250, 500, 600, 300, 120};
		clear_record();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Record of sample zero alone: minimum stays all ones.
		f = '0;
		f.min_v = SMP_W'(SMP_MAX);
		add_row(14'd1234, 1'b1, 1'b1, f);
		// Sample one at full scale is also taken as index zero.
		f = '0;
		f.min_v = SMP_W'(SMP_MAX);
		f.max_v = SMP_W'(SMP_MAX);
		f.bsum = SUM_W'(SMP_MAX);
		add_row(14'd5, 1'b0, 1'b0, '0);
		add_row(14'h3FFF, 1'b1, 1'b1, f);
		// Zero samples: the maximum never moves off index zero.
		add_row(14'h3FFF, 1'b0, 1'b0, '0);
		add_row(14'd0, 1'b1, 1'b1, '0);
		// A record just past the baseline, extremes inside the baseline.
		for (int i = 0; i < 22; i++)
			add_row((i == 7) ? 14'd0 : (i == 12) ? 14'h3FFF : (i == 21) ? 14'd2 :
				14'(8000 + 37 * i), i == 21, 1'b0, '0);
		foreach (dir_rows[i]) send(dir_rows[i].smp, dir_rows[i].lst, dir_rows[i].typed,
			dir_rows[i].want);
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_all(2500, 1250, 500, 600, 300, 120);
				1: write_all(0, 0, 0, 0, 0, 0);
				2: write_all(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
				default: write_all(OFF_W'($urandom_range(0, 3000)),
					OFF_W'($urandom_range(0, 1500)), OFF_W'($urandom_range(0, 600)),
					OFF_W'($urandom_range(0, 3000)), OFF_W'($urandom_range(0, 1500)),
					OFF_W'($urandom_range(0, 600)));
			endcase
			idle_in = (ph != 2);
			idle_out = (ph != 2);
			// Stall the result side while short records keep coming.
			if (ph == 1) begin
				idle_in = 1'b0;
				hold_req = 1'b1;
			end
			phase_items = 0;
			// One record runs past the record length without a closing flag.
			if (ph == 3) send_record($urandom_range(1025, 1040));
			while (phase_items < 90) begin
				if (ph == 1 && !hold_req) idle_in = 1'b1;
				send_record(($urandom_range(0, 5) == 0) ?
					$urandom_range(1, 3) : $urandom_range(4, 45));
			end
			wait_idle();
		end

		if (!failed)
			$display("tb_pulse_record_feature_extractor OK");
		else
			$display("tb_pulse_record_feature_extractor NOT OK");
		$finish;
	end

endmodule
